@@ hw/rtl/sact_pkg.sv @@
// Shared constants, types and helper functions of the set-associative tag store.
package sact_pkg;

    // Fixed geometry of the tag store.
    localparam int ADDR_W           = 32;
    localparam int WAYS             = 4;
    localparam int WAY_W            = $clog2(WAYS);
    localparam int SETS             = 64;
    localparam int SET_W            = $clog2(SETS);
    localparam int TREE_W           = WAYS - 1;
    localparam int GRANULE_LOG2_DEF = 8;

    // Replacement and statistics state.
    localparam int              LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam int              CNT_W     = 32;

    // Result field widths and packed result width (rounded up to whole bytes).
    localparam int OUTCOME_W  = 2;
    localparam int WAY_OUT_W  = 2;
    localparam int LINE_W     = 8;
    localparam int RES_BITS   = OUTCOME_W + WAY_OUT_W + LINE_W + 4 * CNT_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Outcome codes of one access.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    // Replacement mode register values.
    localparam logic MODE_LFSR = 1'b0;
    localparam logic MODE_PLRU = 1'b1;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request address, read its set row
        logic commit;   // write back the set and load the result register
    } dp_cmd_t;

    // Follow the tree bits from the root to the pseudo-LRU way.
    function automatic logic [WAY_W-1:0] plru_victim(input logic [TREE_W-1:0] tree);
        logic [WAY_W:0] node;
        logic           b;
        node = (WAY_W + 1)'(1);
        for (int lv = 0; lv < WAY_W; lv++)
        begin
            b    = tree[WAY_W'(node - 1'b1)];
            node = {node[WAY_W-1:0], b};
        end
        return node[WAY_W-1:0];
    endfunction

    // Point every node on the path of a way away from it.
    function automatic logic [TREE_W-1:0] plru_touch(input logic [TREE_W-1:0] tree,
                                                     input logic [WAY_W-1:0]  way);
        logic [TREE_W-1:0] t;
        logic [WAY_W:0]    node;
        logic              b;
        t    = tree;
        node = (WAY_W + 1)'(1);
        for (int lv = WAY_W - 1; lv >= 0; lv--)
        begin
            b                       = way[lv];
            t[WAY_W'(node - 1'b1)]  = ~b;
            node                    = {node[WAY_W-1:0], b};
        end
        return t;
    endfunction

    // Saturating increment of a statistics counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

@@ hw/rtl/sact_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/sact_ctrl.sv @@
// Controller: request/result handshakes and sequencing of one access at a time.
module sact_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sact_pkg::dp_cmd_t cmd
);

    sact_pkg::state_t state_reg;
    sact_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !m_valid_reg || m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sact_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sact_pkg::ST_LOOK;
                end
            end
            sact_pkg::ST_LOOK:
            begin
                if (slot_free)
                begin
                    state_next = sact_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sact_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            sact_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            sact_pkg::ST_LOOK:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sact_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

@@ hw/rtl/sact_dpath.sv @@
// Datapath: tag RAM, valid bits, way selection, LFSR, counters and result register.
module sact_dpath #(
    parameter int GRANULE_LOG2 = sact_pkg::GRANULE_LOG2_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sact_pkg::dp_cmd_t                 cmd,
    input  logic [sact_pkg::ADDR_W-1:0]       s_addr,
    input  logic                              cfg_we,
    input  logic                              cfg_mode,
    output logic [sact_pkg::OUTCOME_W-1:0]    outcome,
    output logic [sact_pkg::WAY_OUT_W-1:0]    way,
    output logic [sact_pkg::LINE_W-1:0]       line,
    output logic [sact_pkg::CNT_W-1:0]        access_total,
    output logic [sact_pkg::CNT_W-1:0]        hit_total,
    output logic [sact_pkg::CNT_W-1:0]        fill_total,
    output logic [sact_pkg::CNT_W-1:0]        evict_total
);

    localparam int TAG_W = sact_pkg::ADDR_W - GRANULE_LOG2;
    localparam int ROW_W = sact_pkg::TREE_W + sact_pkg::WAYS * TAG_W;
    localparam int WAY_W = sact_pkg::WAY_W;
    localparam int SET_W = sact_pkg::SET_W;

    logic [sact_pkg::ADDR_W-1:0]   addr_reg;
    logic                          mode_reg;
    logic [sact_pkg::LFSR_W-1:0]   lfsr_reg;
    logic [sact_pkg::LFSR_W-1:0]   lfsr_next;
    logic [sact_pkg::WAYS-1:0]     valid_reg [sact_pkg::SETS];
    logic [sact_pkg::WAYS-1:0]     vrow_reg;
    logic [sact_pkg::CNT_W-1:0]    acc_cnt_reg;
    logic [sact_pkg::CNT_W-1:0]    hit_cnt_reg;
    logic [sact_pkg::CNT_W-1:0]    fill_cnt_reg;
    logic [sact_pkg::CNT_W-1:0]    evict_cnt_reg;
    sact_pkg::outcome_t            outcome_reg;
    logic [WAY_W-1:0]              way_reg;
    logic [sact_pkg::LINE_W-1:0]   line_reg;

    logic [TAG_W-1:0]              tag;
    logic [SET_W-1:0]              set_idx;
    logic [SET_W-1:0]              rd_set;
    logic [ROW_W-1:0]              rd_row;
    logic [ROW_W-1:0]              wr_row;
    logic [sact_pkg::WAYS-1:0]     vrow;
    logic [sact_pkg::TREE_W-1:0]   tree_eff;
    logic [sact_pkg::WAYS-1:0]     hit_vec;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              inv_way;
    logic [WAY_W-1:0]              sel_way;
    sact_pkg::outcome_t            sel_outcome;
    logic                          lfsr_fb;
    logic                          lfsr_use;

    // Address split of the request being looked up and of an incoming one.
    assign tag     = addr_reg[sact_pkg::ADDR_W-1:GRANULE_LOG2];
    assign set_idx = tag[SET_W-1:0];
    assign rd_set  = s_addr[GRANULE_LOG2 +: SET_W];

    // One row per set: tree bits on top, then the tags of all ways.
    sact_ram #(
        .WIDTH (ROW_W),
        .DEPTH (sact_pkg::SETS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.commit),
        .wr_addr (set_idx),
        .wr_data (wr_row),
        .rd_en   (cmd.capture),
        .rd_addr (rd_set),
        .rd_data (rd_row)
    );

    // A set that has never been touched has no valid way and reads its tree as zero.
    assign vrow     = vrow_reg;
    assign tree_eff = (|vrow) ? rd_row[ROW_W-1 -: sact_pkg::TREE_W] : '0;

    // Tag compare and lowest matching / lowest free way.
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        for (int w = sact_pkg::WAYS - 1; w >= 0; w--)
        begin
            hit_vec[w] = vrow[w] && (rd_row[w*TAG_W +: TAG_W] == tag);
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!vrow[w])
            begin
                inv_way = WAY_W'(w);
            end
        end
    end

    // Next LFSR value, used only when a random victim is needed.
    assign lfsr_fb   = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_next = {lfsr_fb, lfsr_reg[sact_pkg::LFSR_W-1:1]};

    // Way selection: hit, then first free way, then the victim.
    always_comb
    begin
        lfsr_use = 1'b0;
        priority if (|hit_vec)
        begin
            sel_way     = hit_way;
            sel_outcome = sact_pkg::OUT_HIT;
        end
        else if (!(&vrow))
        begin
            sel_way     = inv_way;
            sel_outcome = sact_pkg::OUT_FILL;
        end
        else if (mode_reg == sact_pkg::MODE_PLRU)
        begin
            sel_way     = sact_pkg::plru_victim(tree_eff);
            sel_outcome = sact_pkg::OUT_EVICT;
        end
        else
        begin
            sel_way     = lfsr_next[WAY_W-1:0];
            sel_outcome = sact_pkg::OUT_EVICT;
            lfsr_use    = 1'b1;
        end
    end

    // Updated row: new tag in the chosen way, tree marked for that way.
    always_comb
    begin
        wr_row = rd_row;
        for (int w = 0; w < sact_pkg::WAYS; w++)
        begin
            if (sel_way == WAY_W'(w))
            begin
                wr_row[w*TAG_W +: TAG_W] = tag;
            end
        end
        wr_row[ROW_W-1 -: sact_pkg::TREE_W] = sact_pkg::plru_touch(tree_eff, sel_way);
    end

    // Request address latch, with the valid bits of its set read alongside the row.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= s_addr;
            vrow_reg <= valid_reg[rd_set];
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            outcome_reg <= sel_outcome;
            way_reg     <= sel_way;
            line_reg    <= sact_pkg::LINE_W'({set_idx, sel_way});
        end
    end

    // Mode register, LFSR and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sact_pkg::MODE_LFSR;
            lfsr_reg      <= sact_pkg::LFSR_SEED;
            acc_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            fill_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_mode;
            end
            if (cmd.commit)
            begin
                acc_cnt_reg <= sact_pkg::sat_inc(acc_cnt_reg);
                if (lfsr_use)
                begin
                    lfsr_reg <= lfsr_next;
                end
                if (sel_outcome == sact_pkg::OUT_HIT)
                begin
                    hit_cnt_reg <= sact_pkg::sat_inc(hit_cnt_reg);
                end
                else if (sel_outcome == sact_pkg::OUT_FILL)
                begin
                    fill_cnt_reg <= sact_pkg::sat_inc(fill_cnt_reg);
                end
                else
                begin
                    evict_cnt_reg <= sact_pkg::sat_inc(evict_cnt_reg);
                end
            end
        end
    end

    // Valid bits, one per way of every set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < sact_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            valid_reg[set_idx][sel_way] <= 1'b1;
        end
    end

    // Counters change only when a result is loaded, so they feed the result directly.
    assign outcome      = outcome_reg;
    assign way          = sact_pkg::WAY_OUT_W'(way_reg);
    assign line         = line_reg;
    assign access_total = acc_cnt_reg;
    assign hit_total    = hit_cnt_reg;
    assign fill_total   = fill_cnt_reg;
    assign evict_total  = evict_cnt_reg;

endmodule

@@ hw/rtl/set_assoc_cache_tag_plru.sv @@
// Top level of the set-associative tag store with tree pseudo-LRU or LFSR replacement.
//
//  Channel   Direction  Handshake                Payload
//  s_*       in         s_tvalid / s_tready      s_tdata: address
//  m_*       out        m_tvalid / m_tready      m_tdata: outcome, way, line, four totals
//  cfg_*     in         cfg_valid / cfg_ready    cfg_data: replacement_mode
//
// Each access is accepted in the idle state, which reads the set's row from the tag RAM;
// the lookup state then compares the tags, picks the way and writes the row back.
// A new request is taken while the previous result still waits in the result register;
// the write-back stalls only while that register is full and not being drained.
// Reset (rst_n, asynchronous) clears the valid bits, counters, LFSR and mode at once;
// no clearing pass is needed.
module set_assoc_cache_tag_plru #(
    parameter int GRANULE_LOG2 = sact_pkg::GRANULE_LOG2_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request: [31:0] address
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sact_pkg::ADDR_W-1:0]        s_tdata,
    // Result: [1:0] outcome, [3:2] way, [11:4] line, [43:12] access_total,
    // [75:44] hit_total, [107:76] fill_total, [139:108] evict_total, [143:140] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sact_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration: [0] replacement_mode
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);

    sact_pkg::dp_cmd_t                  cmd;
    logic [sact_pkg::OUTCOME_W-1:0]     outcome;
    logic [sact_pkg::WAY_OUT_W-1:0]     way;
    logic [sact_pkg::LINE_W-1:0]        line;
    logic [sact_pkg::CNT_W-1:0]         access_total;
    logic [sact_pkg::CNT_W-1:0]         hit_total;
    logic [sact_pkg::CNT_W-1:0]         fill_total;
    logic [sact_pkg::CNT_W-1:0]         evict_total;

    // The mode register can always be written.
    assign cfg_ready = 1'b1;

    sact_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sact_dpath #(
        .GRANULE_LOG2 (GRANULE_LOG2)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .s_addr       (s_tdata),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_mode     (cfg_data),
        .outcome      (outcome),
        .way          (way),
        .line         (line),
        .access_total (access_total),
        .hit_total    (hit_total),
        .fill_total   (fill_total),
        .evict_total  (evict_total)
    );

    // Pack the result, first field in the lowest bits, zero padded to whole bytes.
    assign m_tdata = sact_pkg::OUT_DATA_W'({evict_total, fill_total, hit_total,
                                            access_total, line, way, outcome});

endmodule

@@ tb/tb_set_assoc_cache_tag_plru.sv @@
// Self-checking testbench of the set-associative tag store with LFSR and tree pseudo-LRU replacement.
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_plru;

    localparam int ADDR_W           = sact_pkg::ADDR_W;
    localparam int GRANULE_LOG2_DEF = sact_pkg::GRANULE_LOG2_DEF;
    localparam int WAYS             = sact_pkg::WAYS;
    localparam int WAY_W            = sact_pkg::WAY_W;
    localparam int SETS             = sact_pkg::SETS;
    localparam int SET_W            = sact_pkg::SET_W;
    localparam int TREE_W           = sact_pkg::TREE_W;
    localparam int LFSR_W           = sact_pkg::LFSR_W;
    localparam int CNT_W            = sact_pkg::CNT_W;
    localparam int OUTCOME_W        = sact_pkg::OUTCOME_W;
    localparam int WAY_OUT_W        = sact_pkg::WAY_OUT_W;
    localparam int LINE_W           = sact_pkg::LINE_W;
    localparam int OUT_DATA_W       = sact_pkg::OUT_DATA_W;

    localparam int TAG_W       = ADDR_W - GRANULE_LOG2_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_SLACK = 4;

    // Bit positions of the result fields in m_tdata.
    localparam int WAY_LSB   = OUTCOME_W;
    localparam int LINE_LSB  = WAY_LSB + WAY_OUT_W;
    localparam int ACC_LSB   = LINE_LSB + LINE_W;
    localparam int HIT_LSB   = ACC_LSB + CNT_W;
    localparam int FILL_LSB  = HIT_LSB + CNT_W;
    localparam int EVICT_LSB = FILL_LSB + CNT_W;

    typedef struct {
        sact_pkg::outcome_t outcome;
        logic [WAY_W-1:0]   way;
        logic [LINE_W-1:0]  line_no;
        logic [CNT_W-1:0]   accesses;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   fills;
        logic [CNT_W-1:0]   evicts;
    } access_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ADDR_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data = 1'b0;

    // Shadow copy of the tag store used to work out each expected result.
    bit                    valid_map [SETS][WAYS];
    logic [TAG_W-1:0]      tag_map [SETS][WAYS];
    bit [TREE_W-1:0]       tree_map [SETS];
    logic [LFSR_W-1:0]     lfsr_q = sact_pkg::LFSR_SEED;
    logic                  mode_q = sact_pkg::MODE_LFSR;
    logic [CNT_W-1:0]      access_cnt = '0;
    logic [CNT_W-1:0]      hit_cnt = '0;
    logic [CNT_W-1:0]      fill_cnt = '0;
    logic [CNT_W-1:0]      evict_cnt = '0;

    access_result_t        pending_lookups[$];
    logic [ADDR_W-1:0]     addr_backlog[$];

    bit                    req_fire = 0;
    bit                    res_fire = 0;
    bit                    cfg_fire = 0;
    bit                    steady_flow = 0;
    bit                    hold_req = 0;
    int                    send_gap = 0;
    int                    send_burst = 0;
    int                    rcv_stall = 0;
    int                    rcv_burst = 0;
    int                    hold_cnt = 0;
    int                    idle_cycles = 0;
    int                    fault_count = 0;

    set_assoc_cache_tag_plru #(
        .GRANULE_LOG2 (GRANULE_LOG2_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Look up one address in the shadow store, update it, and return the result it yields.
    function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr);
        access_result_t   r;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set_idx;
        logic [WAY_W-1:0] w;
        logic             fb;
        bit               found;
        int               node;
        int               v;
        int               b;
        tag     = addr[ADDR_W-1:GRANULE_LOG2_DEF];
        set_idx = tag[SET_W-1:0];
        found   = 0;
        w       = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found && valid_map[set_idx][i] && tag_map[set_idx][i] == tag)
            begin
                found = 1;
                w     = WAY_W'(i);
            end
        end
        if (found)
        begin
            r.outcome = sact_pkg::OUT_HIT;
        end
        else
        begin
            // Lowest empty way first, otherwise a victim by the current policy.
            for (int i = 0; i < WAYS; i++)
            begin
                if (!found && !valid_map[set_idx][i])
                begin
                    found = 1;
                    w     = WAY_W'(i);
                end
            end
            if (found)
            begin
                r.outcome = sact_pkg::OUT_FILL;
            end
            else
            begin
                r.outcome = sact_pkg::OUT_EVICT;
                if (mode_q == sact_pkg::MODE_PLRU)
                begin
                    node = 1;
                    v    = 0;
                    for (int lv = 0; lv < WAY_W; lv++)
                    begin
                        b    = tree_map[set_idx][node-1];
                        v    = 2 * v + b;
                        node = 2 * node + b;
                    end
                    w = WAY_W'(v % WAYS);
                end
                else
                begin
                    fb     = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
                    lfsr_q = {fb, lfsr_q[LFSR_W-1:1]};
                    w      = WAY_W'(lfsr_q % WAYS);
                end
            end
        end

        valid_map[set_idx][w] = 1;
        tag_map[set_idx][w]   = tag;

        // Point every tree node on the way's path away from it.
        node = 1;
        for (int lv = WAY_W - 1; lv >= 0; lv--)
        begin
            b                           = w[lv];
            tree_map[set_idx][node-1]   = ~b[0];
            node                        = 2 * node + b;
        end

        if (access_cnt != '1)
            access_cnt++;
        if (r.outcome == sact_pkg::OUT_HIT && hit_cnt != '1)
            hit_cnt++;
        if (r.outcome == sact_pkg::OUT_FILL && fill_cnt != '1)
            fill_cnt++;
        if (r.outcome == sact_pkg::OUT_EVICT && evict_cnt != '1)
            evict_cnt++;

        r.way      = w;
        r.line_no  = LINE_W'({set_idx, w});
        r.accesses = access_cnt;
        r.hits     = hit_cnt;
        r.fills    = fill_cnt;
        r.evicts   = evict_cnt;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] seen);
        if (want !== seen)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        end
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 8);
    endfunction

    function automatic logic [ADDR_W-1:0] make_addr(input logic [31:0] tag_hi,
                                                    input logic [31:0] set_idx,
                                                    input logic [31:0] offset);
        return {tag_hi[TAG_W-SET_W-1:0], set_idx[SET_W-1:0], offset[GRANULE_LOG2_DEF-1:0]};
    endfunction

    // Sample handshakes, predict each accepted request, check each accepted result.
    always @(posedge clk)
    begin : monitor
        access_result_t want;
        req_fire = rst_n && s_tvalid && s_tready;
        res_fire = rst_n && m_tvalid && m_tready;
        cfg_fire = rst_n && cfg_valid && cfg_ready;
        if (cfg_fire)
            mode_q = cfg_data;
        if (req_fire)
            pending_lookups = {pending_lookups, predict_access(s_tdata)};
        if (res_fire)
        begin
            if (pending_lookups.size() == 0)
            begin
                fault_count++;
                $display("%0t: result with no request outstanding, actual %0h", $time, m_tdata);
            end
            else
            begin
                want = pending_lookups.pop_front();
                check_field("outcome", CNT_W'(want.outcome),
                            CNT_W'(m_tdata[0 +: OUTCOME_W]));
                check_field("way", CNT_W'(want.way), CNT_W'(m_tdata[WAY_LSB +: WAY_OUT_W]));
                check_field("line", CNT_W'(want.line_no), CNT_W'(m_tdata[LINE_LSB +: LINE_W]));
                check_field("access_total", want.accesses, m_tdata[ACC_LSB +: CNT_W]);
                check_field("hit_total", want.hits, m_tdata[HIT_LSB +: CNT_W]);
                check_field("fill_total", want.fills, m_tdata[FILL_LSB +: CNT_W]);
                check_field("evict_total", want.evicts, m_tdata[EVICT_LSB +: CNT_W]);
            end
        end

        // Watchdog on cycles in which no handshake completes.
        if (req_fire || res_fire || cfg_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Request driver: offers queued addresses with random gaps and bursts.
    always @(negedge clk)
    begin
        if (!s_tvalid || req_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (addr_backlog.size() != 0)
            begin
                s_tdata  <= addr_backlog.pop_front();
                s_tvalid <= 1'b1;
                if (steady_flow)
                    send_gap = 0;
                else if (send_burst > 0)
                begin
                    send_burst--;
                    send_gap = 0;
                end
                else if ($urandom_range(40) == 0)
                begin
                    send_burst = $urandom_range(50, 15);
                    send_gap   = 0;
                end
                else
                    send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls, bursts of steady acceptance, one long hold-off.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (rcv_stall > 0)
        begin
            rcv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rcv_burst > 0)
                rcv_burst--;
            else if ($urandom_range(40) == 0)
                rcv_burst = $urandom_range(50, 15);
            else
                rcv_stall = pick_gap();
        end
    end

    // Append one address to the backlog of pending requests.
    task automatic queue_addr(input logic [ADDR_W-1:0] a);
        addr_backlog = {addr_backlog, a};
    endtask

    // Wait until every queued request is sent and every result is back.
    task automatic wait_drained();
        while (addr_backlog.size() != 0 || s_tvalid || pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        wait_drained();
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Random requests focused on a few sets and tags, mixed with repeats and wild addresses.
    task automatic run_random(input int count, input bit with_hold);
        logic [31:0]       pool_set [6];
        logic [31:0]       pool_tag [6][6];
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last_addr;
        int                r;
        for (int s = 0; s < 6; s++)
        begin
            pool_set[s] = $urandom_range(SETS - 1);
            for (int t = 0; t < 6; t++)
                pool_tag[s][t] = $urandom;
        end
        last_addr = $urandom;

        // Long result hold-off while requests keep coming back to back.
        if (with_hold)
        begin
            @(posedge clk);
            steady_flow = 1;
            hold_req    = 1;
            for (int i = 0; i < 40; i++)
            begin
                r = $urandom_range(5);
                queue_addr(make_addr(pool_tag[r][$urandom_range(5)], pool_set[r], $urandom));
            end
            wait_drained();
            steady_flow = 0;
            count -= 40;
        end

        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                r    = $urandom_range(5);
                addr = make_addr(pool_tag[r][$urandom_range(5)], pool_set[r], $urandom);
            end
            else if (r < 82)
                addr = {last_addr[ADDR_W-1:GRANULE_LOG2_DEF], 8'($urandom)};
            else
                addr = $urandom;
            queue_addr(addr);
            last_addr = addr;
            // Sender pauses now and then until every result has come back.
            if (i % 150 == 149)
                wait_drained();
        end
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under LFSR replacement: address extremes, hits, fills, evictions.
        write_mode(sact_pkg::MODE_LFSR);
        queue_addr(32'h0000_0000);
        queue_addr(32'hFFFF_FFFF);
        queue_addr(32'h0000_00FF);
        queue_addr(32'hFFFF_FF00);
        for (int k = 0; k < 6; k++)
            queue_addr(make_addr(k, 5, 0));
        queue_addr(make_addr(0, 5, 32'h7F));
        queue_addr(make_addr(5, 5, 32'h01));

        // Directed part under tree pseudo-LRU: evictions in a full set, then a hit.
        write_mode(sact_pkg::MODE_PLRU);
        for (int k = 6; k < 10; k++)
            queue_addr(make_addr(k, 5, 0));
        queue_addr(make_addr(9, 5, 32'hFF));
        queue_addr(make_addr(1, 63, 0));
        queue_addr(make_addr(1, 63, 0));

        run_random(350, 0);
        write_mode(sact_pkg::MODE_LFSR);
        run_random(350, 1);
        write_mode(sact_pkg::MODE_PLRU);
        run_random(380, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fault_count == 0 && pending_lookups.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ set_assoc_cache_tag_plru.f @@
hw/rtl/sact_pkg.sv
hw/rtl/sact_ram.sv
hw/rtl/sact_ctrl.sv
hw/rtl/sact_dpath.sv
hw/rtl/set_assoc_cache_tag_plru.sv
tb/tb_set_assoc_cache_tag_plru.sv
